### rtl/quaternion_vector_rotate_top_assert.svh
// Assertion macros shared by the quaternion vector rotation RTL.
// No dependencies; the including module supplies the clock and reset names.
`ifndef QUATERNION_VECTOR_ROTATE_TOP_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define QVR_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("qvr: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define QVR_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("qvr: next-cycle check failed");

`endif

### rtl/qvr_pkg.sv
// Shared types, constants and width helpers for the quaternion vector rotator.
// No dependencies; used by every module under rtl.
package qvr_pkg;

  localparam int VEC_WIDTH_DEF = 16;
  localparam int QUAT_W        = 16;
  localparam int QEXT_W        = QUAT_W + 1;  // holds +32768 after negation
  localparam int OUT_W         = 18;
  localparam int FRAC_BITS     = 15;
  localparam int RND_HALF      = 1 << (FRAC_BITS - 1);
  localparam int REG_IDX_W     = 2;

  localparam logic [REG_IDX_W-1:0] REG_QUAT_REAL = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_QUAT_X    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_QUAT_Y    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_QUAT_Z    = 2'd3;

  localparam logic signed [QUAT_W-1:0] QUAT_REAL_RST = 16'sh7FFF;
  localparam logic signed [QUAT_W-1:0] QUAT_IMAG_RST = 16'sh0000;

  localparam logic signed [OUT_W-1:0] ROT_MAX = 18'sh1FFFF;
  localparam logic signed [OUT_W-1:0] ROT_MIN = 18'sh20000;

  typedef struct packed {
    logic signed [QUAT_W-1:0] re;
    logic signed [QUAT_W-1:0] x;
    logic signed [QUAT_W-1:0] y;
    logic signed [QUAT_W-1:0] z;
  } quat_t;

  // Width of the rounded first product q*(0,v).
  function automatic int lift_width(input int vec_w);
    return vec_w + QEXT_W + 2 - FRAC_BITS;
  endfunction

  // Width of the rounded second product p*q'.
  function automatic int proj_width(input int p_w);
    return p_w + QEXT_W + 2 - FRAC_BITS;
  endfunction

  // Sign-extend a quaternion part, negate it for the conjugate.
  function automatic logic signed [QEXT_W-1:0] conj_part(
    input logic signed [QUAT_W-1:0] v,
    input logic                     neg
  );
    logic signed [QEXT_W-1:0] e;
    e = QEXT_W'(v);
    return neg ? -e : e;
  endfunction

endpackage

### rtl/quaternion_vector_rotate_top.sv
// Top level of the quaternion vector rotator: config registers and stage chain.
// Depends on qvr_pkg, qvr_lift, qvr_project, qvr_sat and the assertion header.
//
// Rotates a signed vector (in_vec_x/y/z, VEC_WIDTH bits) by the quaternion held
// in four Q1.15 registers, computing the vector part of q*v*q'; in_operation=1
// uses the conjugate, giving the inverse rotation. No normalization is done, so
// a non-unit quaternion scales the result by |q|^2. Each product stage rounds
// its sums half-up by 15 fraction bits; results saturate to signed 18 bits and
// out_clipped reports that any component was clamped. Throughput is one vector
// per clock while the output is not stalled; from input transaction to result
// valid lie two registers in the first product stage (twelve multipliers, then
// rounded sums), two in the second (twelve more multipliers, then rounded sums)
// and the saturating output register. A stage stalls only when it is full and its
// next stalls, so bubbles are squeezed out and nothing is dropped or repeated.
// Write the quaternion through cfg_we/cfg_index/cfg_wdata only while no
// transaction is in flight; reset loads the identity rotation.

`include "quaternion_vector_rotate_top_assert.svh"

module quaternion_vector_rotate_top #(
  parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic [qvr_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic [qvr_pkg::QUAT_W-1:0]           cfg_wdata,
  // input transactions
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_operation,
  input  logic signed [VEC_WIDTH-1:0]          in_vec_x,
  input  logic signed [VEC_WIDTH-1:0]          in_vec_y,
  input  logic signed [VEC_WIDTH-1:0]          in_vec_z,
  // result transactions
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [qvr_pkg::OUT_W-1:0]     out_rot_x,
  output logic signed [qvr_pkg::OUT_W-1:0]     out_rot_y,
  output logic signed [qvr_pkg::OUT_W-1:0]     out_rot_z,
  output logic                                 out_clipped
);

  localparam int PW = qvr_pkg::lift_width(VEC_WIDTH);
  localparam int RW = qvr_pkg::proj_width(PW);

  qvr_pkg::quat_t quat_r, quat_nxt;

  // Register file: decode the index, hold every other register.
  always_comb begin
    quat_nxt = quat_r;
    if (cfg_we) begin
      unique case (cfg_index)
        qvr_pkg::REG_QUAT_REAL: quat_nxt.re = $signed(cfg_wdata);
        qvr_pkg::REG_QUAT_X:    quat_nxt.x  = $signed(cfg_wdata);
        qvr_pkg::REG_QUAT_Y:    quat_nxt.y  = $signed(cfg_wdata);
        qvr_pkg::REG_QUAT_Z:    quat_nxt.z  = $signed(cfg_wdata);
        default:                quat_nxt    = quat_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_r.re <= qvr_pkg::QUAT_REAL_RST;
      quat_r.x  <= qvr_pkg::QUAT_IMAG_RST;
      quat_r.y  <= qvr_pkg::QUAT_IMAG_RST;
      quat_r.z  <= qvr_pkg::QUAT_IMAG_RST;
    end else begin
      quat_r <= quat_nxt;
    end
  end

  // First product: p = q*(0,v).
  logic                 lift_valid, lift_ready, lift_op;
  logic signed [PW-1:0] p_w, p_i, p_j, p_k;

  qvr_lift #(.VEC_WIDTH(VEC_WIDTH)) u_lift (
    .clk       (clk),
    .rst_n     (rst_n),
    .quat      (quat_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_operation),
    .vec_x     (in_vec_x),
    .vec_y     (in_vec_y),
    .vec_z     (in_vec_z),
    .out_valid (lift_valid),
    .out_ready (lift_ready),
    .out_op    (lift_op),
    .p_w       (p_w),
    .p_i       (p_i),
    .p_j       (p_j),
    .p_k       (p_k)
  );

  // Second product: vector part of p*q'.
  logic                 proj_valid, proj_ready;
  logic signed [RW-1:0] r_x, r_y, r_z;

  qvr_project #(.VEC_WIDTH(VEC_WIDTH)) u_project (
    .clk       (clk),
    .rst_n     (rst_n),
    .quat      (quat_r),
    .in_valid  (lift_valid),
    .in_ready  (lift_ready),
    .in_op     (lift_op),
    .p_w       (p_w),
    .p_i       (p_i),
    .p_j       (p_j),
    .p_k       (p_k),
    .out_valid (proj_valid),
    .out_ready (proj_ready),
    .r_x       (r_x),
    .r_y       (r_y),
    .r_z       (r_z)
  );

  // Saturate and hold the result until the consumer takes it.
  qvr_sat #(.VEC_WIDTH(VEC_WIDTH)) u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (proj_valid),
    .in_ready  (proj_ready),
    .r_x       (r_x),
    .r_y       (r_y),
    .r_z       (r_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rot_x     (out_rot_x),
    .rot_y     (out_rot_y),
    .rot_z     (out_rot_z),
    .clipped   (out_clipped)
  );

  // A write to the scalar register lands in the next cycle.
  `QVR_ASSERT_NEXT(a_cfg_real_write, clk, rst_n, cfg_we && (cfg_index == qvr_pkg::REG_QUAT_REAL), quat_r.re == $signed($past(cfg_wdata)))
  // With the result register empty, every stage can advance.
  `QVR_ASSERT_IMPL(a_empty_accepts, clk, rst_n, !out_valid, in_ready)
  // A clipped result has at least one component pinned at a limit.
  `QVR_ASSERT_IMPL(a_clip_at_limit, clk, rst_n, out_valid && out_clipped, (out_rot_x == qvr_pkg::ROT_MAX) || (out_rot_x == qvr_pkg::ROT_MIN) || (out_rot_y == qvr_pkg::ROT_MAX) || (out_rot_y == qvr_pkg::ROT_MIN) || (out_rot_z == qvr_pkg::ROT_MAX) || (out_rot_z == qvr_pkg::ROT_MIN))
  // Nothing comes out in the first cycle after reset.
  `QVR_ASSERT_IMPL(a_idle_after_reset, clk, rst_n, $past(!rst_n), !out_valid)

endmodule

### rtl/qvr_lift.sv
// First product stage: p = q*(0,v), two register stages (products, rounded sums).
// Depends on qvr_pkg.
module qvr_lift #(
  parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH_DEF,
  localparam int PW = qvr_pkg::lift_width(VEC_WIDTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  qvr_pkg::quat_t        quat,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic signed [VEC_WIDTH-1:0] vec_x,
  input  logic signed [VEC_WIDTH-1:0] vec_y,
  input  logic signed [VEC_WIDTH-1:0] vec_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_op,
  output logic signed [PW-1:0]  p_w,
  output logic signed [PW-1:0]  p_i,
  output logic signed [PW-1:0]  p_j,
  output logic signed [PW-1:0]  p_k
);

  localparam int MW = VEC_WIDTH + qvr_pkg::QEXT_W;
  localparam int SW = MW + 2;

  logic signed [qvr_pkg::QEXT_W-1:0] qa, qb, qc, qd;
  logic signed [MW-1:0] term_nxt [4][3];
  logic signed [MW-1:0] term_r   [4][3];
  logic signed [SW-1:0] e        [4][3];
  logic signed [SW-1:0] sum      [4];
  logic signed [PW-1:0] p_nxt    [4];
  logic signed [PW-1:0] p_r      [4];
  logic valid_a_r, valid_b_r, op_a_r, op_b_r;
  logic en_a, en_b;

  assign en_b     = !valid_b_r || out_ready;
  assign en_a     = !valid_a_r || en_b;
  assign in_ready = en_a;

  always_comb begin
    qa = qvr_pkg::conj_part(quat.re, 1'b0);
    qb = qvr_pkg::conj_part(quat.x, in_op);
    qc = qvr_pkg::conj_part(quat.y, in_op);
    qd = qvr_pkg::conj_part(quat.z, in_op);
    // rows: w, i, j, k
    term_nxt[0][0] = qb * vec_x;
    term_nxt[0][1] = qc * vec_y;
    term_nxt[0][2] = qd * vec_z;
    term_nxt[1][0] = qa * vec_x;
    term_nxt[1][1] = qc * vec_z;
    term_nxt[1][2] = qd * vec_y;
    term_nxt[2][0] = qa * vec_y;
    term_nxt[2][1] = qb * vec_z;
    term_nxt[2][2] = qd * vec_x;
    term_nxt[3][0] = qa * vec_z;
    term_nxt[3][1] = qb * vec_y;
    term_nxt[3][2] = qc * vec_x;
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        e[r][c] = SW'(term_r[r][c]);
      end
    end
    sum[0] = -e[0][0] - e[0][1] - e[0][2];
    sum[1] =  e[1][0] + e[1][1] - e[1][2];
    sum[2] =  e[2][0] - e[2][1] + e[2][2];
    sum[3] =  e[3][0] + e[3][1] - e[3][2];
    for (int r = 0; r < 4; r++) begin
      sum[r]   = sum[r] + SW'(qvr_pkg::RND_HALF);
      p_nxt[r] = sum[r][SW-1:qvr_pkg::FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
    end else begin
      if (en_a) valid_a_r <= in_valid;
      if (en_b) valid_b_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_valid) begin
      term_r <= term_nxt;
      op_a_r <= in_op;
    end
    if (en_b && valid_a_r) begin
      p_r    <= p_nxt;
      op_b_r <= op_a_r;
    end
  end

  assign out_valid = valid_b_r;
  assign out_op    = op_b_r;
  assign p_w       = p_r[0];
  assign p_i       = p_r[1];
  assign p_j       = p_r[2];
  assign p_k       = p_r[3];

endmodule

### rtl/qvr_project.sv
// Second product stage: vector part of p*q', two register stages.
// Depends on qvr_pkg.
module qvr_project #(
  parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH_DEF,
  localparam int PW = qvr_pkg::lift_width(VEC_WIDTH),
  localparam int RW = qvr_pkg::proj_width(PW)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  qvr_pkg::quat_t       quat,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic signed [PW-1:0] p_w,
  input  logic signed [PW-1:0] p_i,
  input  logic signed [PW-1:0] p_j,
  input  logic signed [PW-1:0] p_k,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [RW-1:0] r_x,
  output logic signed [RW-1:0] r_y,
  output logic signed [RW-1:0] r_z
);

  localparam int MW = PW + qvr_pkg::QEXT_W;
  localparam int SW = MW + 2;

  logic signed [qvr_pkg::QEXT_W-1:0] qa, qb, qc, qd;
  logic signed [MW-1:0] term_nxt [3][4];
  logic signed [MW-1:0] term_r   [3][4];
  logic signed [SW-1:0] e        [3][4];
  logic signed [SW-1:0] sum      [3];
  logic signed [RW-1:0] r_nxt    [3];
  logic signed [RW-1:0] r_r      [3];
  logic valid_a_r, valid_b_r;
  logic en_a, en_b;

  assign en_b     = !valid_b_r || out_ready;
  assign en_a     = !valid_a_r || en_b;
  assign in_ready = en_a;

  always_comb begin
    qa = qvr_pkg::conj_part(quat.re, 1'b0);
    qb = qvr_pkg::conj_part(quat.x, in_op);
    qc = qvr_pkg::conj_part(quat.y, in_op);
    qd = qvr_pkg::conj_part(quat.z, in_op);
    // rows: x, y, z; columns follow pw, pi, pj, pk
    term_nxt[0][0] = p_w * qb;
    term_nxt[0][1] = p_i * qa;
    term_nxt[0][2] = p_j * qd;
    term_nxt[0][3] = p_k * qc;
    term_nxt[1][0] = p_w * qc;
    term_nxt[1][1] = p_i * qd;
    term_nxt[1][2] = p_j * qa;
    term_nxt[1][3] = p_k * qb;
    term_nxt[2][0] = p_w * qd;
    term_nxt[2][1] = p_i * qc;
    term_nxt[2][2] = p_j * qb;
    term_nxt[2][3] = p_k * qa;
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        e[r][c] = SW'(term_r[r][c]);
      end
    end
    sum[0] = -e[0][0] + e[0][1] - e[0][2] + e[0][3];
    sum[1] = -e[1][0] + e[1][1] + e[1][2] - e[1][3];
    sum[2] = -e[2][0] - e[2][1] + e[2][2] + e[2][3];
    for (int r = 0; r < 3; r++) begin
      sum[r]   = sum[r] + SW'(qvr_pkg::RND_HALF);
      r_nxt[r] = sum[r][SW-1:qvr_pkg::FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
    end else begin
      if (en_a) valid_a_r <= in_valid;
      if (en_b) valid_b_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_valid) term_r <= term_nxt;
    if (en_b && valid_a_r) r_r <= r_nxt;
  end

  assign out_valid = valid_b_r;
  assign r_x       = r_r[0];
  assign r_y       = r_r[1];
  assign r_z       = r_r[2];

endmodule

### rtl/qvr_sat.sv
// Output stage: saturate to 18 bits, flag clipping, hold the result register.
// Depends on qvr_pkg.
module qvr_sat #(
  parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH_DEF,
  localparam int RW = qvr_pkg::proj_width(qvr_pkg::lift_width(VEC_WIDTH))
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [RW-1:0]             r_x,
  input  logic signed [RW-1:0]             r_y,
  input  logic signed [RW-1:0]             r_z,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [qvr_pkg::OUT_W-1:0] rot_x,
  output logic signed [qvr_pkg::OUT_W-1:0] rot_y,
  output logic signed [qvr_pkg::OUT_W-1:0] rot_z,
  output logic                             clipped
);

  localparam int OW = qvr_pkg::OUT_W;
  localparam int EW = (RW > OW) ? RW : OW;

  // Returns {clip, value}.
  function automatic logic [OW:0] clamp(input logic signed [RW-1:0] v);
    logic signed [EW-1:0] ext;
    ext = EW'(v);
    if (ext > EW'(qvr_pkg::ROT_MAX)) begin
      clamp = {1'b1, qvr_pkg::ROT_MAX};
    end else if (ext < EW'(qvr_pkg::ROT_MIN)) begin
      clamp = {1'b1, qvr_pkg::ROT_MIN};
    end else begin
      clamp = {1'b0, ext[OW-1:0]};
    end
  endfunction

  logic [OW:0] cx, cy, cz;
  logic signed [OW-1:0] rot_x_r, rot_y_r, rot_z_r;
  logic clipped_r, valid_r, en;

  assign cx = clamp(r_x);
  assign cy = clamp(r_y);
  assign cz = clamp(r_z);

  assign en       = !valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      rot_x_r   <= cx[OW-1:0];
      rot_y_r   <= cy[OW-1:0];
      rot_z_r   <= cz[OW-1:0];
      clipped_r <= cx[OW] | cy[OW] | cz[OW];
    end
  end

  assign out_valid = valid_r;
  assign rot_x     = rot_x_r;
  assign rot_y     = rot_y_r;
  assign rot_z     = rot_z_r;
  assign clipped   = clipped_r;

endmodule

### verif/quaternion_rotate_checker.sv
`timescale 1ns / 100ps
// Checker for the quaternion vector rotator: watches config writes and both channels.
// Predicts each rotation from its own quaternion copy; depends on qvr_pkg only.
module quaternion_rotate_checker #(
  parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [qvr_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [qvr_pkg::QUAT_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              in_operation,
  input  logic signed [VEC_WIDTH-1:0]       in_vec_x,
  input  logic signed [VEC_WIDTH-1:0]       in_vec_y,
  input  logic signed [VEC_WIDTH-1:0]       in_vec_z,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [qvr_pkg::OUT_W-1:0]  out_rot_x,
  input  logic signed [qvr_pkg::OUT_W-1:0]  out_rot_y,
  input  logic signed [qvr_pkg::OUT_W-1:0]  out_rot_z,
  input  logic                              out_clipped,
  output int                                mismatch_count,
  output int                                rotations_checked,
  output int                                clipped_count,
  output int                                rotations_pending
);
  import qvr_pkg::*;

  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    logic                    clipped;
  } rotation_t;

  quat_t     quat_now;
  rotation_t rotations_due[$];
  int        n_mismatch = 0;
  int        n_checked  = 0;
  int        n_clipped  = 0;
  int        n_pending  = 0;

  assign mismatch_count    = n_mismatch;
  assign rotations_checked = n_checked;
  assign clipped_count     = n_clipped;
  assign rotations_pending = n_pending;

  // Round half-up: arithmetic shift floors, the added half does the rest.
  function automatic longint round_half_up(input longint s);
    return (s + longint'(RND_HALF)) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_out(input longint v);
    if (v > longint'(ROT_MAX)) return ROT_MAX;
    if (v < longint'(ROT_MIN)) return ROT_MIN;
    return OUT_W'(v);
  endfunction

  function automatic rotation_t predict_rotation(
    input logic                        inverse,
    input logic signed [VEC_WIDTH-1:0] vx,
    input logic signed [VEC_WIDTH-1:0] vy,
    input logic signed [VEC_WIDTH-1:0] vz,
    input quat_t                       q
  );
    longint    a, b, c, d, x, y, z;
    longint    pw, pi, pj, pk, rx, ry, rz;
    rotation_t r;
    a = longint'($signed(q.re));
    b = longint'($signed(q.x));
    c = longint'($signed(q.y));
    d = longint'($signed(q.z));
    x = longint'(vx);
    y = longint'(vy);
    z = longint'(vz);
    // conjugate: negate the vector part, -(-32768) stays exact here
    if (inverse) begin
      b = -b;
      c = -c;
      d = -d;
    end
    pw = round_half_up(-b * x - c * y - d * z);
    pi = round_half_up(a * x + c * z - d * y);
    pj = round_half_up(a * y - b * z + d * x);
    pk = round_half_up(a * z + b * y - c * x);
    rx = round_half_up(-pw * b + pi * a - pj * d + pk * c);
    ry = round_half_up(-pw * c + pi * d + pj * a - pk * b);
    rz = round_half_up(-pw * d - pi * c + pj * b + pk * a);
    r.x = clamp_out(rx);
    r.y = clamp_out(ry);
    r.z = clamp_out(rz);
    r.clipped = (longint'(r.x) != rx) || (longint'(r.y) != ry) || (longint'(r.z) != rz);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (n_mismatch < MAX_REPORTS)
      $display("[%0t] rotation mismatch on %s: got %0d, want %0d", $time, what, got, want);
    n_mismatch++;
  endtask

  always @(posedge clk) begin : watch_channels
    rotation_t want;
    if (!rst_n) begin
      quat_now = '{re: QUAT_REAL_RST, x: QUAT_IMAG_RST, y: QUAT_IMAG_RST, z: QUAT_IMAG_RST};
      rotations_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_QUAT_REAL: quat_now.re = cfg_wdata;
          REG_QUAT_X:    quat_now.x  = cfg_wdata;
          REG_QUAT_Y:    quat_now.y  = cfg_wdata;
          REG_QUAT_Z:    quat_now.z  = cfg_wdata;
          default: ;
        endcase
      end
      // check the result first: it can never belong to an input taken this edge
      if (out_valid && out_ready) begin
        if (rotations_due.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = rotations_due.pop_front();
          if (out_rot_x !== want.x) report_mismatch("rot_x", out_rot_x, want.x);
          if (out_rot_y !== want.y) report_mismatch("rot_y", out_rot_y, want.y);
          if (out_rot_z !== want.z) report_mismatch("rot_z", out_rot_z, want.z);
          if (out_clipped !== want.clipped)
            report_mismatch("clipped", out_clipped, want.clipped);
          n_checked++;
          if (want.clipped) n_clipped++;
        end
      end
      if (in_valid && in_ready)
        rotations_due.push_back(predict_rotation(in_operation, in_vec_x, in_vec_y,
                                                 in_vec_z, quat_now));
    end
    n_pending <= rotations_due.size();
  end

endmodule

### verif/quaternion_vector_rotate_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the quaternion vector rotator: clock, reset, stimulus, verdict.
// Depends on qvr_pkg, the RTL under rtl and quaternion_rotate_checker.
module quaternion_vector_rotate_top_tb;
  import qvr_pkg::*;

  localparam int VEC_W          = VEC_WIDTH_DEF;
  localparam int N_PHASES       = 9;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int DRAIN_CYCLES   = 8;
  localparam int LONG_HOLD      = 300;   // output stall that backs up the input
  localparam int WATCHDOG_LIMIT = 2000;

  logic                    clk          = 1'b0;
  logic                    rst_n        = 1'b0;
  logic                    cfg_we       = 1'b0;
  logic [REG_IDX_W-1:0]    cfg_index    = REG_QUAT_REAL;
  logic [QUAT_W-1:0]       cfg_wdata    = '0;
  logic                    in_valid     = 1'b0;
  logic                    in_ready;
  logic                    in_operation = 1'b0;
  logic signed [VEC_W-1:0] in_vec_x     = '0;
  logic signed [VEC_W-1:0] in_vec_y     = '0;
  logic signed [VEC_W-1:0] in_vec_z     = '0;
  logic                    out_valid;
  logic                    out_ready    = 1'b0;
  logic signed [OUT_W-1:0] out_rot_x;
  logic signed [OUT_W-1:0] out_rot_y;
  logic signed [OUT_W-1:0] out_rot_z;
  logic                    out_clipped;

  int    mismatch_count;
  int    rotations_checked;
  int    clipped_count;
  int    rotations_pending;

  int    send_idle_pct  = 23;
  int    recv_idle_pct  = 55;
  bit    long_hold_req  = 1'b0;
  int    quiet_cycles   = 0;
  quat_t quat_plan[N_PHASES];

  quaternion_vector_rotate_top #(.VEC_WIDTH(VEC_W)) dut (.*);

  quaternion_rotate_checker #(.VEC_WIDTH(VEC_W)) u_checker (.*);

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: end the run once no transaction has moved for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no transaction for %0d cycles", $time, quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Result side: stall at random, and hold off for a long stretch on request so
  // the pipeline fills and pushes back on the input.
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        for (int n = 0; n < LONG_HOLD; n++) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Pick a component, leaning on the extremes now and then.
  function automatic logic signed [15:0] rand_component();
    case ($urandom_range(15))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      3:       return 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one vector; return at the edge where the transaction is taken.
  task automatic send_vector(input logic op, input logic signed [VEC_W-1:0] x,
                             input logic signed [VEC_W-1:0] y,
                             input logic signed [VEC_W-1:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_vec_x     <= x;
    in_vec_y     <= y;
    in_vec_z     <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Wait until every predicted rotation has come back and the pipe is empty.
  task automatic drain_pipeline();
    repeat (2) @(posedge clk);
    while (rotations_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all four quaternion registers on consecutive edges.
  task automatic load_quat(input quat_t q);
    cfg_we    <= 1'b1;
    cfg_index <= REG_QUAT_REAL;
    cfg_wdata <= q.re;
    @(posedge clk);
    cfg_index <= REG_QUAT_X;
    cfg_wdata <= q.x;
    @(posedge clk);
    cfg_index <= REG_QUAT_Y;
    cfg_wdata <= q.y;
    @(posedge clk);
    cfg_index <= REG_QUAT_Z;
    cfg_wdata <= q.z;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    // Settings: identity, both extremes, zero, a quarter turn about z, then
    // arbitrary (mostly non-unit) quaternions.
    quat_plan[0] = '{re: 16'sh7FFF, x: 16'sh0000, y: 16'sh0000, z: 16'sh0000};
    quat_plan[1] = '{re: 16'sh8000, x: 16'sh8000, y: 16'sh8000, z: 16'sh8000};
    quat_plan[2] = '{re: 16'sh7FFF, x: 16'sh7FFF, y: 16'sh7FFF, z: 16'sh7FFF};
    quat_plan[3] = '{re: 16'sh0000, x: 16'sh0000, y: 16'sh0000, z: 16'sh0000};
    quat_plan[4] = '{re: 16'sd23170, x: 16'sh0000, y: 16'sh0000, z: 16'sd23170};
    for (int p = 5; p < N_PHASES; p++)
      quat_plan[p] = '{re: rand_component(), x: rand_component(),
                       y: rand_component(), z: rand_component()};

    // Hold reset, then release it for good.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed vectors under the reset quaternion, forward and inverse.
    for (int op = 0; op < 2; op++) begin
      send_vector(op[0], 16'sh0000, 16'sh0000, 16'sh0000);
      send_vector(op[0], 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_vector(op[0], 16'sh8000, 16'sh8000, 16'sh8000);
      send_vector(op[0], 16'sh7FFF, 16'sh8000, 16'sh0000);
      send_vector(op[0], 16'shFFFF, 16'sh0001, 16'shFFFF);
      send_vector(op[0], 16'sh0001, 16'sh0000, 16'sh0000);
      send_vector(op[0], 16'sh0000, 16'sh0001, 16'sh0000);
      send_vector(op[0], 16'sh0000, 16'sh0000, 16'sh0001);
    end
    in_valid <= 1'b0;
    drain_pipeline();

    for (int p = 0; p < N_PHASES; p++) begin
      load_quat(quat_plan[p]);
      // Receiver idles more than sender first, then the reverse, then no idling.
      if (p < 3) begin
        send_idle_pct = 23;
        recv_idle_pct = 55;
      end else if (p < 6) begin
        send_idle_pct = 55;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Stall the output for a long stretch while the input keeps offering.
      if (p == 6) long_hold_req = 1'b1;
      // Most negative quaternion: full-scale vectors, including the exact
      // negation of -32768 under the inverse rotation.
      if (p == 1) begin
        for (int op = 0; op < 2; op++) begin
          send_vector(op[0], 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
          send_vector(op[0], 16'sh8000, 16'sh8000, 16'sh8000);
        end
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        send_vector(1'($urandom_range(1)), rand_component(), rand_component(),
                    rand_component());
      in_valid <= 1'b0;
      drain_pipeline();
    end

    $display("Rotated %0d vectors through %0d quaternion settings, forward and inverse.",
             rotations_checked, N_PHASES + 1);
    $display("%0d results saturated; idle gaps on both sides and one long output stall.",
             clipped_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
